FILE: sv/ray_sphere_intersection_macros.svh
// ----------------------------------------------------------------------------
// ray_sphere_intersection_macros.svh
// Assertion macros used by the port-level checker of the ray/sphere block.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECTION_MACROS_SVH
`define RAY_SPHERE_INTERSECTION_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSI_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ray_sphere_intersection: same-cycle check failed");

// next-cycle implication, disabled during reset
`define RSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ray_sphere_intersection: next-cycle check failed");

`endif

FILE: sv/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared codes, widths and the sphere table entry type.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISC_TOL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_T_MIN        = 2'd2;
  localparam logic [30:0] TOL_RST  = 31'd655;
  localparam logic [16:0] TMIN_RST = 17'd655;

  // commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_PRIMARY = 2'd1;
  localparam logic [1:0] CMD_SHADOW  = 2'd2;

  // datapath widths
  localparam int unsigned OPW  = 68;   // A, B, G and wide multiplier operands
  localparam int unsigned PRW  = 136;  // wide products and Q
  localparam int unsigned SQW  = 134;  // square root radicand
  localparam int unsigned RTW  = 67;   // square root result
  localparam int unsigned NUMW = 70;   // root numerator -B +- s
  localparam int unsigned TOL_SHIFT = 46;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic        [30:0] r;
  } sphere_t;

endpackage

FILE: sv/rsi_req_if.sv
// ----------------------------------------------------------------------------
// rsi_req_if
// Request channel: load beats and ray query beats.
// ----------------------------------------------------------------------------
interface rsi_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  command;
  logic        [3:0]  entry_index;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic        [30:0] radius;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;

  modport source (output valid, command, entry_index, center_x, center_y, center_z, radius,
                  dir_x, dir_y, dir_z, origin_x, origin_y, origin_z, input ready);
  modport sink (input valid, command, entry_index, center_x, center_y, center_z, radius,
                dir_x, dir_y, dir_z, origin_x, origin_y, origin_z, output ready);
endinterface

FILE: sv/rsi_rsp_if.sv
// ----------------------------------------------------------------------------
// rsi_rsp_if
// Response channel: one beat per request beat.
// ----------------------------------------------------------------------------
interface rsi_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic        [3:0]  hit_entry;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] root;

  modport source (output valid, hit, hit_entry, point_x, point_y, point_z, root,
                  input ready);
  modport sink (input valid, hit, hit_entry, point_x, point_y, point_z, root,
                output ready);
endinterface

FILE: sv/rsi_mem.sv
// ----------------------------------------------------------------------------
// rsi_mem
// Sphere table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rsi_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  rsi_pkg::sphere_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output rsi_pkg::sphere_t rdata
);

  rsi_pkg::sphere_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/rsi_mul.sv
// ----------------------------------------------------------------------------
// rsi_mul
// Wide signed multiplier, one 8-bit digit of the multiplier per cycle.
// ----------------------------------------------------------------------------
module rsi_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [rsi_pkg::OPW-1:0]  a,
  input  logic signed [rsi_pkg::OPW-1:0]  b,
  output logic                            done,
  output logic signed [rsi_pkg::PRW-1:0]  p
);

  localparam int W    = rsi_pkg::OPW;
  localparam int PW   = rsi_pkg::PRW;
  localparam int DIG  = 8;
  localparam int NDIG = (W + DIG - 1) / DIG;
  localparam int MBW  = NDIG * DIG;
  localparam int CW   = $clog2(NDIG + 1);

  logic [W-1:0]     ma;
  logic [MBW-1:0]   mb;
  logic [PW-1:0]    acc;
  logic [W+DIG-1:0] pp;
  logic             neg;
  logic             busy;
  logic [CW-1:0]    cnt;

  // partial product of the top remaining digit
  always_comb begin
    pp = ma * mb[MBW-1 -: DIG];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        neg  <= a[W-1] ^ b[W-1];
        ma   <= a[W-1] ? W'(-a) : W'(a);
        mb   <= b[W-1] ? MBW'(W'(-b)) : MBW'(W'(b));
      end else if (busy) begin
        if (cnt == CW'(NDIG)) begin
          p    <= neg ? -$signed(acc) : $signed(acc);
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          acc <= (acc << DIG) + PW'(pp);
          mb  <= mb << DIG;
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

endmodule

FILE: sv/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// Floor square root, restoring, one result bit per cycle.
// ----------------------------------------------------------------------------
module rsi_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rsi_pkg::SQW-1:0]   n,
  output logic                      done,
  output logic [rsi_pkg::RTW-1:0]   s
);

  localparam int NW   = rsi_pkg::SQW;
  localparam int RW   = rsi_pkg::RTW;
  localparam int REMW = RW + 3;
  localparam int CW   = $clog2(RW + 1);

  logic [NW-1:0]   nsh;
  logic [REMW-1:0] rem;
  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            ge;
  logic            busy;
  logic [CW-1:0]   cnt;

  // next bit pair and trial subtract
  always_comb begin
    rem_sh = {rem[REMW-3:0], nsh[NW-1 -: 2]};
    trial  = {1'b0, s, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        nsh  <= n;
        rem  <= '0;
        s    <= '0;
      end else if (busy) begin
        if (cnt == CW'(RW)) begin
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          rem <= ge ? rem_sh - trial : rem_sh;
          s   <= {s[RW-2:0], ge};
          nsh <= nsh << 2;
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

endmodule

FILE: sv/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div
// Floor of num * 2^16 / den, den positive, one quotient bit per cycle,
// saturated to signed 32 bits.
// ----------------------------------------------------------------------------
module rsi_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [rsi_pkg::NUMW-1:0]  num,
  input  logic        [63:0]               den,
  output logic                             done,
  output logic signed [31:0]               q_out
);

  localparam int NW   = rsi_pkg::NUMW;
  localparam int SW   = NW + 16;
  localparam int MW   = SW + 2;
  localparam int REMW = 65;
  localparam int CW   = $clog2(MW + 1);

  logic signed [SW-1:0] ns;
  logic [MW-1:0]        mag_in;
  logic [MW-1:0]        q;
  logic [REMW-1:0]      rem;
  logic [REMW-1:0]      rem_sh;
  logic [63:0]          den_r;
  logic                 ge;
  logic                 neg;
  logic                 busy;
  logic [CW-1:0]        cnt;

  // magnitude, biased so a truncating divide gives the floor
  always_comb begin
    ns     = {num, 16'd0};
    mag_in = num[NW-1] ? MW'(-ns) + MW'(den) - MW'(1) : MW'(ns);
    rem_sh = {rem[REMW-2:0], q[MW-1]};
    ge     = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        q     <= mag_in;
        rem   <= '0;
        den_r <= den;
        neg   <= num[NW-1];
      end else if (busy) begin
        if (cnt == CW'(MW)) begin
          // saturate and apply sign
          if (!neg) begin
            q_out <= (q > MW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
          end else begin
            q_out <= (q > MW'(32'h8000_0000)) ? 32'sh8000_0000 :
                     $signed(~q[31:0] + 32'd1);
          end
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          rem <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
          q   <= {q[MW-2:0], ge};
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

endmodule

FILE: sv/ray_sphere_intersection.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersection
// First-hit ray/sphere search over a loadable sphere table.
//
//   channel   dir   beat carries
//   req       in    load entry, or primary/shadow query ray
//   rsp       out   hit flag, entry, hit point, root (zeros unless hit)
//   cfg       in    write-only registers: count, tolerance, t_min
//
// A load or unused command is answered straight from S_DONE. A query tests
// each sphere in turn (table read, 10 products on the 34x34 multiplier, and
// unless A is zero two wide products for Q); a sphere whose Q lies above the
// tangent band adds a square root, and each root costs a division, one or two
// per sphere. Hits add three products on the small multiplier for the point.
// Reset is synchronous; the table keeps its contents. A new request is taken
// while the previous response waits; the next response then stalls in place.
// ----------------------------------------------------------------------------
module ray_sphere_intersection #(
  parameter int MAX_SPHERES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]  cfg_data,
  rsi_req_if.sink                         req,
  rsi_rsp_if.source                       rsp
);

  localparam int AW  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int KW  = $clog2(MAX_SPHERES + 1);
  localparam int OPW = rsi_pkg::OPW;
  localparam int PRW = rsi_pkg::PRW;
  localparam int NMW = rsi_pkg::NUMW;
  localparam logic [3:0] PROD_END = 4'd10;
  localparam logic [3:0] PNT_END  = 4'd3;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_RD    = 11'b000_0000_0010,
    S_VEC   = 11'b000_0000_0100,
    S_PROD  = 11'b000_0000_1000,
    S_QBB   = 11'b000_0001_0000,
    S_QAG   = 11'b000_0010_0000,
    S_CLASS = 11'b000_0100_0000,
    S_SQRT  = 11'b000_1000_0000,
    S_DIV   = 11'b001_0000_0000,
    S_PNT   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    DK_TAN  = 2'd0,
    DK_NEAR = 2'd1,
    DK_FAR  = 2'd2
  } div_kind_t;

  state_t    state;
  div_kind_t div_kind;

  // configuration registers
  logic [4:0]  sphere_count;
  logic [30:0] disc_tol;
  logic [16:0] t_min;

  // query registers
  logic               shadow;
  logic signed [31:0] d [3];
  logic signed [31:0] o [3];
  logic signed [32:0] v [3];
  logic        [30:0] rad;
  logic [KW-1:0]      k;
  logic [KW-1:0]      k_inc;
  logic [KW-1:0]      n_cnt;
  logic [KW-1:0]      n_next;
  logic [3:0]         pc;
  logic signed [OPW-1:0] acc_a, acc_b, acc_g;
  logic signed [PRW-1:0] q;
  logic signed [PRW-1:0] thr_s;
  logic               gt_thr, gt_nthr;
  logic signed [31:0] t_r;

  // small multiplier pipeline
  logic signed [33:0] sm_a, sm_b;
  logic signed [67:0] prod;
  logic [3:0]         prod_tag;
  logic               prod_vld, prod_pnt, issue;

  // result staging and output registers
  logic               res_hit;
  logic [3:0]         res_entry;
  logic signed [31:0] res_px, res_py, res_pz, res_root;
  logic               out_valid, out_hit;
  logic [3:0]         out_entry;
  logic signed [31:0] out_px, out_py, out_pz, out_root;

  // shared units
  logic                  mem_we, mem_re;
  rsi_pkg::sphere_t      mem_wdata, mem_rdata;
  logic                  mul_start, mul_done;
  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [PRW-1:0] mul_p;
  logic                  sqrt_start, sqrt_done;
  logic [rsi_pkg::RTW-1:0] sq_s;
  logic                  div_start, div_done;
  logic signed [NMW-1:0] div_num, nb, nb_minus_s, nb_plus_s;
  logic signed [31:0]    div_q;
  logic                  pos, win, div_take, div_retry, adv;

  function automatic logic signed [31:0] sat_pt(input logic signed [31:0] org,
                                                input logic signed [67:0] pr);
    logic signed [67:0] sum;
    begin
      sum = $signed({{36{org[31]}}, org}) + (pr >>> 16);
      if (sum > 68'sd2147483647) begin
        sat_pt = 32'sh7FFF_FFFF;
      end else if (sum < -68'sd2147483648) begin
        sat_pt = 32'sh8000_0000;
      end else begin
        sat_pt = sum[31:0];
      end
    end
  endfunction

  // handshake and port drive
  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.hit       = out_hit;
  assign rsp.hit_entry = out_entry;
  assign rsp.point_x   = out_px;
  assign rsp.point_y   = out_py;
  assign rsp.point_z   = out_pz;
  assign rsp.root      = out_root;

  // table write on a load beat, read of entry k
  assign mem_we = (state == S_IDLE) && req.valid && (req.command == rsi_pkg::CMD_LOAD) &&
                  (32'(req.entry_index) < 32'(MAX_SPHERES));
  assign mem_wdata = '{cx: req.center_x, cy: req.center_y, cz: req.center_z, r: req.radius};
  assign mem_re = (state == S_RD);

  rsi_mem #(.DEPTH(MAX_SPHERES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(req.entry_index)),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (AW'(k)),
    .rdata (mem_rdata)
  );

  // entries searched and loop bookkeeping
  assign n_next = (32'(sphere_count) < 32'(MAX_SPHERES)) ? KW'(sphere_count) :
                  KW'(MAX_SPHERES);
  assign k_inc  = k + KW'(1);

  // discriminant band
  assign thr_s   = $signed(PRW'({disc_tol, 46'd0}));
  assign gt_thr  = q > thr_s;
  assign gt_nthr = q > -thr_s;

  // small multiplier operands
  always_comb begin
    sm_a = '0;
    sm_b = '0;
    if (state == S_PNT) begin
      sm_a = {{2{t_r[31]}}, t_r};
      case (pc)
        4'd0:    sm_b = {{2{d[0][31]}}, d[0]};
        4'd1:    sm_b = {{2{d[1][31]}}, d[1]};
        4'd2:    sm_b = {{2{d[2][31]}}, d[2]};
        default: sm_b = '0;
      endcase
    end else begin
      case (pc)
        4'd0: begin sm_a = {{2{d[0][31]}}, d[0]}; sm_b = sm_a; end
        4'd1: begin sm_a = {{2{d[1][31]}}, d[1]}; sm_b = sm_a; end
        4'd2: begin sm_a = {{2{d[2][31]}}, d[2]}; sm_b = sm_a; end
        4'd3: begin sm_a = {{2{d[0][31]}}, d[0]}; sm_b = {v[0][32], v[0]}; end
        4'd4: begin sm_a = {{2{d[1][31]}}, d[1]}; sm_b = {v[1][32], v[1]}; end
        4'd5: begin sm_a = {{2{d[2][31]}}, d[2]}; sm_b = {v[2][32], v[2]}; end
        4'd6: begin sm_a = {v[0][32], v[0]}; sm_b = sm_a; end
        4'd7: begin sm_a = {v[1][32], v[1]}; sm_b = sm_a; end
        4'd8: begin sm_a = {v[2][32], v[2]}; sm_b = sm_a; end
        4'd9: begin sm_a = $signed({3'd0, rad}); sm_b = sm_a; end
        default: begin sm_a = '0; sm_b = '0; end
      endcase
    end
  end

  assign issue = ((state == S_PROD) && (pc < PROD_END)) || ((state == S_PNT) && (pc < PNT_END));

  // wide multiplier: B*B, then A*G
  assign mul_start = ((state == S_PROD) && (pc == PROD_END) && (acc_a != '0)) ||
                     ((state == S_QBB) && mul_done);
  assign mul_a = (state == S_PROD) ? acc_b : acc_a;
  assign mul_b = (state == S_PROD) ? acc_b : acc_g;

  rsi_mul u_mul (
    .clk (clk), .rst (rst), .start (mul_start),
    .a (mul_a), .b (mul_b), .done (mul_done), .p (mul_p)
  );

  assign sqrt_start = (state == S_CLASS) && gt_thr;

  rsi_sqrt u_sqrt (
    .clk (clk), .rst (rst), .start (sqrt_start),
    .n (q[rsi_pkg::SQW-1:0]), .done (sqrt_done), .s (sq_s)
  );

  // root numerators and the accept decision
  always_comb begin
    nb         = -$signed({{(NMW-OPW){acc_b[OPW-1]}}, acc_b});
    nb_minus_s = nb - $signed(NMW'(sq_s));
    nb_plus_s  = nb + $signed(NMW'(sq_s));
    pos        = div_q > 32'sd0;
    win        = (div_q > $signed({15'd0, t_min})) && (div_q <= rsi_pkg::ONE_Q16);
    div_take   = 1'b0;
    div_retry  = 1'b0;
    case (div_kind)
      DK_NEAR: begin div_take = pos; div_retry = !pos; end
      DK_FAR:  div_take = shadow ? win : pos;
      default: div_take = !shadow || win;
    endcase
    if (state == S_CLASS) begin
      div_num = nb;
    end else if (state == S_SQRT) begin
      div_num = shadow ? nb_plus_s : nb_minus_s;
    end else begin
      div_num = nb_plus_s;
    end
    div_start = ((state == S_CLASS) && !gt_thr && gt_nthr) ||
                ((state == S_SQRT) && sqrt_done) ||
                ((state == S_DIV) && div_done && div_retry);
    adv = ((state == S_PROD) && (pc == PROD_END) && (acc_a == '0)) ||
          ((state == S_CLASS) && !gt_thr && !gt_nthr) ||
          ((state == S_DIV) && div_done && !div_take && !div_retry);
  end

  rsi_div u_div (
    .clk (clk), .rst (rst), .start (div_start),
    .num (div_num), .den (acc_a[63:0]), .done (div_done), .q_out (div_q)
  );

  // product pipeline register
  always_ff @(posedge clk) begin
    prod     <= sm_a * sm_b;
    prod_tag <= pc;
    prod_pnt <= (state == S_PNT);
  end

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      prod_vld     <= 1'b0;
      sphere_count <= 5'd0;
      disc_tol     <= rsi_pkg::TOL_RST;
      t_min        <= rsi_pkg::TMIN_RST;
      div_kind     <= DK_TAN;
    end else begin
      prod_vld <= issue;

      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          rsi_pkg::CFG_SPHERE_COUNT: sphere_count <= cfg_data[4:0];
          rsi_pkg::CFG_DISC_TOL:     disc_tol     <= cfg_data[30:0];
          rsi_pkg::CFG_T_MIN:        t_min        <= cfg_data[16:0];
          default: ;
        endcase
      end

      // response taken; S_DONE refills it itself
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      // accumulate products
      if (prod_vld) begin
        if (prod_pnt) begin
          case (prod_tag)
            4'd0:    res_px <= sat_pt(o[0], prod);
            4'd1:    res_py <= sat_pt(o[1], prod);
            default: res_pz <= sat_pt(o[2], prod);
          endcase
        end else begin
          case (prod_tag) inside
            [4'd0:4'd2]: acc_a <= acc_a + OPW'(prod);
            [4'd3:4'd5]: acc_b <= acc_b + OPW'(prod);
            [4'd6:4'd8]: acc_g <= acc_g + OPW'(prod);
            default:     acc_g <= acc_g - OPW'(prod);
          endcase
        end
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            res_hit   <= 1'b0;
            res_entry <= 4'd0;
            res_px    <= '0;
            res_py    <= '0;
            res_pz    <= '0;
            res_root  <= '0;
            if ((req.command == rsi_pkg::CMD_PRIMARY) || (req.command == rsi_pkg::CMD_SHADOW)) begin
              shadow <= (req.command == rsi_pkg::CMD_SHADOW);
              d[0]   <= req.dir_x;
              d[1]   <= req.dir_y;
              d[2]   <= req.dir_z;
              o[0]   <= req.origin_x;
              o[1]   <= req.origin_y;
              o[2]   <= req.origin_z;
              k      <= '0;
              n_cnt  <= n_next;
              state  <= (n_next == '0) ? S_DONE : S_RD;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RD: begin
          state <= S_VEC;
        end
        S_VEC: begin
          v[0]  <= {o[0][31], o[0]} - {mem_rdata.cx[31], mem_rdata.cx};
          v[1]  <= {o[1][31], o[1]} - {mem_rdata.cy[31], mem_rdata.cy};
          v[2]  <= {o[2][31], o[2]} - {mem_rdata.cz[31], mem_rdata.cz};
          rad   <= mem_rdata.r;
          acc_a <= '0;
          acc_b <= '0;
          acc_g <= '0;
          pc    <= '0;
          state <= S_PROD;
        end
        S_PROD: begin
          if (pc == PROD_END) begin
            if (acc_a != '0) begin
              state <= S_QBB;
            end
          end else begin
            pc <= pc + 4'd1;
          end
        end
        S_QBB: begin
          if (mul_done) begin
            q     <= mul_p;
            state <= S_QAG;
          end
        end
        S_QAG: begin
          if (mul_done) begin
            q     <= q - mul_p;
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (gt_thr) begin
            state <= S_SQRT;
          end else if (gt_nthr) begin
            div_kind <= DK_TAN;
            state    <= S_DIV;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            div_kind <= shadow ? DK_FAR : DK_NEAR;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_take) begin
              t_r       <= div_q;
              res_hit   <= 1'b1;
              res_entry <= 4'(k);
              res_root  <= div_q;
              pc        <= '0;
              state     <= S_PNT;
            end else if (div_retry) begin
              div_kind <= DK_FAR;
            end
          end
        end
        S_PNT: begin
          if (pc == PNT_END) begin
            state <= S_DONE;
          end else begin
            pc <= pc + 4'd1;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_hit   <= res_hit;
            out_entry <= res_entry;
            out_px    <= res_px;
            out_py    <= res_py;
            out_pz    <= res_pz;
            out_root  <= res_root;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // sphere rejected: next entry or miss
      if (adv) begin
        if (k_inc == n_cnt) begin
          state <= S_DONE;
        end else begin
          k     <= k_inc;
          state <= S_RD;
        end
      end
    end
  end

endmodule

FILE: sv/rsi_checker.sv
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks for ray_sphere_intersection, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_sphere_intersection_macros.svh"

module rsi_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               rsp_hit,
  input logic        [3:0]  rsp_hit_entry,
  input logic signed [31:0] rsp_point_x,
  input logic signed [31:0] rsp_point_y,
  input logic signed [31:0] rsp_point_z,
  input logic signed [31:0] rsp_root
);

  logic [132:0] rsp_payload;
  logic         miss_zero;

  // whole response payload; everything below the hit flag
  assign rsp_payload = {rsp_hit, rsp_hit_entry, rsp_point_x, rsp_point_y, rsp_point_z,
                        rsp_root};
  assign miss_zero   = (rsp_payload[131:0] == '0);

  // a stalled response beat stays and holds its payload
  `RSI_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `RSI_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp_payload))

  // a miss or load acknowledge carries all-zero fields
  `RSI_ASSERT_SAME(a_miss_zero, clk, rst, rsp_valid && !rsp_hit, miss_zero)

  // one request in work at a time
  `RSI_ASSERT_NEXT(a_one_in_work, clk, rst, req_valid && req_ready, !req_ready)

endmodule

bind ray_sphere_intersection rsi_checker u_rsi_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_hit       (rsp.hit),
  .rsp_hit_entry (rsp.hit_entry),
  .rsp_point_x   (rsp.point_x),
  .rsp_point_y   (rsp.point_y),
  .rsp_point_z   (rsp.point_z),
  .rsp_root      (rsp.root)
);

FILE: dv/rsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_scoreboard
// Watches the request, response and register ports of the ray/sphere block.
// Every accepted request beat is traced through an exact wide-integer copy
// of the sphere search, and every response beat is compared with the oldest
// traced result.
// ----------------------------------------------------------------------------
module rsi_scoreboard (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsi_pkg::CFG_DATA_W-1:0] cfg_data,
  rsi_req_if                             req,
  rsi_rsp_if                             rsp,
  output int                             errors,
  output int                             pending
);

  localparam int unsigned TABLE_DEPTH = 16;

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic               hit;
    logic        [3:0]  entry;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] root;
  } hit_t;

  localparam logic signed [31:0] I32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] I32_MIN = 32'sh80000000;

  hit_t             hits_due[$];
  rsi_pkg::sphere_t spheres[TABLE_DEPTH];
  logic [4:0]  count_r;
  logic [30:0] tol_r;
  logic [16:0] tmin_r;

  function automatic logic signed [31:0] sat32(wide_t v);
    if (v > wide_t'(I32_MAX)) return I32_MAX;
    if (v < wide_t'(I32_MIN)) return I32_MIN;
    return v[31:0];
  endfunction

  // floor square root, n >= 0
  function automatic wide_t floor_sqrt(wide_t n);
    logic [191:0] rem = n;
    logic [191:0] res = '0;
    logic [191:0] bitv = 192'd1 << 190;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return wide_t'(res);
  endfunction

  // floor(num * 2^16 / a), a > 0, saturated
  function automatic logic signed [31:0] ray_param(wide_t num, wide_t a);
    wide_t n = num <<< 16;
    wide_t q = n / a;
    if (n < 0 && q * a != n) q = q - 1;
    return sat32(q);
  endfunction

  function automatic logic signed [31:0] hit_coord(logic signed [31:0] o,
                                                   logic signed [31:0] d,
                                                   logic signed [31:0] t);
    longint prod = longint'(t) * longint'(d);
    longint p = longint'(o) + (prod >>> 16);
    if (p > longint'(I32_MAX)) p = longint'(I32_MAX);
    if (p < longint'(I32_MIN)) p = longint'(I32_MIN);
    return p[31:0];
  endfunction

  // first accepted sphere of a query; loads update the table
  function automatic hit_t trace_ray();
    hit_t   res = '0;
    logic signed [31:0] d[3];
    logic signed [31:0] o[3];
    logic signed [31:0] c[3];
    wide_t  thr, a, b, g, q, s, rr;
    logic signed [31:0] t, r1, r2;
    int     n, tmin_i;
    bit     take;
    if (req.command == rsi_pkg::CMD_LOAD) begin
      spheres[req.entry_index] = '{req.center_x, req.center_y, req.center_z, req.radius};
      return res;
    end
    if (req.command != rsi_pkg::CMD_PRIMARY && req.command != rsi_pkg::CMD_SHADOW) return res;
    d = '{req.dir_x, req.dir_y, req.dir_z};
    o = '{req.origin_x, req.origin_y, req.origin_z};
    thr = wide_t'(tol_r) <<< rsi_pkg::TOL_SHIFT;
    tmin_i = int'(tmin_r);
    n = (count_r > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_r);
    for (int k = 0; k < n; k++) begin
      c = '{spheres[k].cx, spheres[k].cy, spheres[k].cz};
      a = 0; b = 0; g = 0;
      for (int i = 0; i < 3; i++) begin
        a = a + wide_t'(d[i]) * wide_t'(d[i]);
        b = b + wide_t'(d[i]) * (wide_t'(o[i]) - wide_t'(c[i]));
        g = g + (wide_t'(o[i]) - wide_t'(c[i])) * (wide_t'(o[i]) - wide_t'(c[i]));
      end
      rr = wide_t'(spheres[k].r);
      g = g - rr * rr;
      if (a == 0) continue;
      q = b * b - a * g;
      b = -b;
      take = 0;
      t = 0;
      if (q > thr) begin
        // two roots
        s = floor_sqrt(q);
        r1 = ray_param(b - s, a);
        r2 = ray_param(b + s, a);
        if (req.command == rsi_pkg::CMD_PRIMARY) begin
          if (r1 > 0) begin t = r1; take = 1; end
          else if (r2 > 0) begin t = r2; take = 1; end
        end else begin
          t = r2;
          take = (int'(t) > tmin_i) && (t <= rsi_pkg::ONE_Q16);
        end
      end else if (q > -thr) begin
        // tangent
        t = ray_param(b, a);
        take = (req.command == rsi_pkg::CMD_PRIMARY) ||
               ((int'(t) > tmin_i) && (t <= rsi_pkg::ONE_Q16));
      end
      if (take) begin
        res.hit   = 1'b1;
        res.entry = k[3:0];
        res.px    = hit_coord(o[0], d[0], t);
        res.py    = hit_coord(o[1], d[1], t);
        res.pz    = hit_coord(o[2], d[2], t);
        res.root  = t;
        return res;
      end
    end
    return res;
  endfunction

  // register mirror, prediction on request beats, compare on response beats
  always @(posedge clk) begin
    hit_t got, exp_hit;
    if (rst) begin
      count_r = '0;
      tol_r   = rsi_pkg::TOL_RST;
      tmin_r  = rsi_pkg::TMIN_RST;
      hits_due.delete();
      errors  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rsi_pkg::CFG_SPHERE_COUNT: count_r = cfg_data[4:0];
          rsi_pkg::CFG_DISC_TOL:     tol_r   = cfg_data[30:0];
          rsi_pkg::CFG_T_MIN:        tmin_r  = cfg_data[16:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) hits_due.push_back(trace_ray());
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.hit, rsp.hit_entry, rsp.point_x, rsp.point_y, rsp.point_z, rsp.root};
        if (hits_due.size() == 0) begin
          errors++;
          $display("%0t: response beat with nothing due: %p", $time, got);
        end else begin
          exp_hit = hits_due.pop_front();
          if (got !== exp_hit) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, exp_hit, got);
          end
        end
      end
    end
    pending = hits_due.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives loads and ray queries into the ray/sphere block over several
// register settings and handshake pressure levels; a checker beside the
// block traces each query and compares every response beat.
// ----------------------------------------------------------------------------
module tb;

  localparam int ONE = 65536;
  localparam int NUM_PHASES = 6;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic        [1:0]  command;
    logic        [3:0]  entry_index;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [30:0] radius;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
  } beat_t;

  // random phases: sphere count, tolerance, t_min, sender idle %, stall %, beats
  int ph_count[NUM_PHASES] = '{3, 2, 3, 1, 31, 0};
  int ph_tol[NUM_PHASES]   = '{655, 0, 1000, 2147483647, 655, 655};
  int ph_tmin[NUM_PHASES]  = '{655, 0, 32768, 65536, 1, 0};
  int ph_idle[NUM_PHASES]  = '{0, 51, 0, 14, 0, 51};
  int ph_stall[NUM_PHASES] = '{0, 0, 51, 14, 0, 51};
  int ph_beats[NUM_PHASES] = '{500, 450, 450, 400, 80, 70};

  logic clk = 1'b0;
  logic rst;
  logic                           cfg_we;
  logic [rsi_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rsi_pkg::CFG_DATA_W-1:0] cfg_data;
  int errors, pending;
  int idle_pct, stall_pct;
  int active_count;
  rsi_pkg::sphere_t shapes[16];

  rsi_req_if req_ch();
  rsi_rsp_if rsp_ch();

  ray_sphere_intersection i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  rsi_scoreboard i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .errors    (errors),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #200ms;
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic signed [31:0] coord(int span_units);
    return $signed($urandom_range(0, 2 * span_units * ONE)) - span_units * ONE;
  endfunction

  function automatic beat_t noise_beat();
    beat_t b;
    logic [383:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
    b = raw[$bits(beat_t)-1:0];
    return b;
  endfunction

  function automatic beat_t load_beat(int idx, bit wild);
    beat_t b = '0;
    if (wild) b = noise_beat();
    b.command     = rsi_pkg::CMD_LOAD;
    b.entry_index = idx[3:0];
    if (!wild) begin
      b.center_x = coord(8);
      b.center_y = coord(8);
      b.center_z = coord(8);
      b.radius   = 31'($urandom_range(ONE / 4, 4 * ONE));
    end
    return b;
  endfunction

  // ray aimed near a loaded sphere that the current count reaches
  function automatic beat_t aimed_query(logic [1:0] cmd);
    beat_t b = '0;
    int n = (active_count > 16) ? 16 : ((active_count < 1) ? 1 : active_count);
    int k = $urandom_range(0, n - 1);
    logic signed [31:0] tx, ty, tz;
    tx = shapes[k].cx + coord(1);
    ty = shapes[k].cy + coord(1);
    tz = shapes[k].cz + coord(1);
    b.command  = cmd;
    b.origin_x = tx + coord(10);
    b.origin_y = ty + coord(10);
    b.origin_z = tz + coord(10);
    b.dir_x = tx - b.origin_x;
    b.dir_y = ty - b.origin_y;
    b.dir_z = tz - b.origin_z;
    case ($urandom_range(0, 3))
      0: begin b.dir_x = b.dir_x <<< 1; b.dir_y = b.dir_y <<< 1; b.dir_z = b.dir_z <<< 1; end
      1: begin b.dir_x = b.dir_x >>> 1; b.dir_y = b.dir_y >>> 1; b.dir_z = b.dir_z >>> 1; end
      2: begin b.dir_x = -b.dir_x; b.dir_y = -b.dir_y; b.dir_z = -b.dir_z; end
      default: ;
    endcase
    return b;
  endfunction

  task automatic send_beat(beat_t b);
    int gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (b.command == rsi_pkg::CMD_LOAD)
      shapes[b.entry_index] = '{b.center_x, b.center_y, b.center_z, b.radius};
    req_ch.valid       <= 1'b1;
    req_ch.command     <= b.command;
    req_ch.entry_index <= b.entry_index;
    req_ch.center_x    <= b.center_x;
    req_ch.center_y    <= b.center_y;
    req_ch.center_z    <= b.center_z;
    req_ch.radius      <= b.radius;
    req_ch.dir_x       <= b.dir_x;
    req_ch.dir_y       <= b.dir_y;
    req_ch.dir_z       <= b.dir_z;
    req_ch.origin_x    <= b.origin_x;
    req_ch.origin_y    <= b.origin_y;
    req_ch.origin_z    <= b.origin_z;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // lower valid and let every response drain
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [rsi_pkg::CFG_IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[rsi_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_ray(logic [1:0] cmd, int dx, int dy, int dz,
                              int ox, int oy, int oz);
    beat_t b = '0;
    b.command = cmd;
    b.dir_x = dx; b.dir_y = dy; b.dir_z = dz;
    b.origin_x = ox; b.origin_y = oy; b.origin_z = oz;
    send_beat(b);
  endtask

  initial begin
    beat_t b;
    int    pick;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    req_ch.valid <= 1'b0;
    {req_ch.command, req_ch.entry_index, req_ch.center_x, req_ch.center_y,
     req_ch.center_z, req_ch.radius, req_ch.dir_x, req_ch.dir_y, req_ch.dir_z,
     req_ch.origin_x, req_ch.origin_y, req_ch.origin_z} <= '0;
    idle_pct     = 0;
    stall_pct    = 0;
    active_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole table: unit sphere at the origin, extreme entry last
    b = '0;
    b.command = rsi_pkg::CMD_LOAD;
    b.radius  = 31'(ONE);
    send_beat(b);
    for (int i = 1; i < 15; i++) send_beat(load_beat(i, 0));
    b.entry_index = 4'd15;
    b.center_x = 32'sh7fffffff;
    b.center_y = 32'sh80000000;
    b.center_z = 32'sh7fffffff;
    b.radius   = 31'h7fffffff;
    send_beat(b);
    drain();
    write_reg(rsi_pkg::CFG_SPHERE_COUNT, 16);
    active_count = 16;

    // directed: two-root hit, tangent, zero direction, shadow bounds, extremes
    directed_ray(rsi_pkg::CMD_PRIMARY, ONE, 0, 0, -5 * ONE, 0, 0);
    directed_ray(rsi_pkg::CMD_PRIMARY, ONE, 0, 0, -5 * ONE, ONE, 0);
    directed_ray(rsi_pkg::CMD_SHADOW, ONE, 0, 0, -5 * ONE, ONE, 0);
    directed_ray(rsi_pkg::CMD_PRIMARY, 0, 0, 0, 0, 0, 0);
    directed_ray(rsi_pkg::CMD_PRIMARY, -ONE, 0, 0, -5 * ONE, 0, 0);
    directed_ray(rsi_pkg::CMD_SHADOW, 3 * ONE, 0, 0, -2 * ONE, 0, 0);
    directed_ray(rsi_pkg::CMD_SHADOW, 2 * ONE, 0, 0, -2 * ONE, 0, 0);
    directed_ray(rsi_pkg::CMD_PRIMARY, ONE, 0, 0, 0, 0, 0);
    directed_ray(rsi_pkg::CMD_PRIMARY, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh80000000, 32'sh80000000, 32'sh80000000);
    directed_ray(rsi_pkg::CMD_SHADOW, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    b = noise_beat();
    b.command = CMD_UNUSED;
    send_beat(b);
    drain();

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(rsi_pkg::CFG_SPHERE_COUNT, ph_count[p]);
      write_reg(rsi_pkg::CFG_DISC_TOL, ph_tol[p]);
      write_reg(rsi_pkg::CFG_T_MIN, ph_tmin[p]);
      active_count = ph_count[p];
      idle_pct  = ph_idle[p];
      stall_pct = ph_stall[p];
      for (int i = 0; i < ph_beats[p]; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) b = load_beat($urandom_range(0, 15), $urandom_range(0, 9) == 0);
        else if (pick < 13) begin b = noise_beat(); b.command = CMD_UNUSED; end
        else if (pick < 28) begin
          b = noise_beat();
          b.command = $urandom_range(0, 1) ? rsi_pkg::CMD_PRIMARY : rsi_pkg::CMD_SHADOW;
        end
        else b = aimed_query(pick < 64 ? rsi_pkg::CMD_PRIMARY : rsi_pkg::CMD_SHADOW);
        send_beat(b);
      end
      drain();
    end

    stall_pct = 0;
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
